>>> design/pts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the process table scheduler.
// Used by pts_ctrl, pts_datapath and process_table_scheduler; depends on nothing.
package pts_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int BURST_WIDTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Scheduling policies.
  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_RR   = 2'd1;
  localparam logic [1:0] MODE_SJF  = 2'd2;
  localparam logic [1:0] MODE_PRIO = 2'd3;

  // Input commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM    = 2'd1;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;

  typedef struct packed {
    logic              command;
    logic [15:0]       proc_id;
    logic [15:0]       burst_time;
    logic signed [7:0] prio_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ran_id;
    logic [3:0]  ran_slot;
    logic [15:0] burst_left;
    logic        finished;
    logic        all_done;
    logic        error_flag;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_init;
    logic keep_cur;
    logic scan_step;
    logic sel_best;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic tick_empty;
    logic keep_avail;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/pts_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the process table scheduler.
// Depends on pts_pkg for the command and status structs.
module pts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pts_pkg::dp_status_t status,
  output pts_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FETCH  = 3'd4;
  localparam logic [2:0] ST_EXEC   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_load || status.tick_empty) begin
          state_nxt = ST_EXEC;
        end else if (status.keep_avail) begin
          cmd.keep_cur = 1'b1;
          state_nxt    = ST_FETCH;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.sel_best = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.sel_best = 1'b1;
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/pts_datapath.sv
`timescale 1ns / 1ps
// Table storage, selection scan, burst update and result register of the scheduler.
// Depends on pts_pkg; driven by pts_ctrl through the command struct.
module pts_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pts_pkg::in_item_t                   in_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output pts_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  pts_pkg::ctrl_cmd_t                  cmd,
  output pts_pkg::dp_status_t                 status
);

  localparam int IW = pts_pkg::IDX_W;
  localparam int CW = pts_pkg::CNT_W;
  localparam int BW = pts_pkg::BURST_WIDTH;

  logic [BW-1:0]       burst_mem [pts_pkg::TABLE_DEPTH];
  logic signed [7:0]   prio_mem  [pts_pkg::TABLE_DEPTH];
  logic [15:0]         id_mem    [pts_pkg::TABLE_DEPTH];

  logic [BW-1:0]       burst_q_r;
  logic signed [7:0]   prio_q_r;
  logic [15:0]         id_q_r;

  logic [pts_pkg::TABLE_DEPTH-1:0] done_r;
  logic [pts_pkg::TABLE_DEPTH-1:0] done_nxt;
  logic [CW-1:0]       entry_count_r, entry_count_nxt;
  logic [CW-1:0]       remaining_r, remaining_nxt;
  logic [IW-1:0]       current_slot_r, current_slot_nxt;
  logic                current_valid_r, current_valid_nxt;
  logic [1:0]          mode_r;
  logic [7:0]          quantum_r;

  pts_pkg::in_item_t   item_r;

  logic [IW-1:0]       k_r, k_nxt;
  logic                pend_valid_r;
  logic [IW-1:0]       pend_slot_r;
  logic                best_found_r, best_found_nxt;
  logic [IW-1:0]       best_slot_r, best_slot_nxt;
  logic [BW-1:0]       best_burst_r, best_burst_nxt;
  logic signed [7:0]   best_prio_r, best_prio_nxt;

  pts_pkg::out_item_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CW:0]         rr_start;
  logic [CW:0]         rr_sum;
  logic [IW-1:0]       scan_addr;
  logic [IW-1:0]       rd_addr;
  logic                take;
  logic                table_full;
  logic                run_tick;
  logic [BW-1:0]       quantum_ext;
  logic [BW-1:0]       burst_new;
  logic                fin;
  logic                mem_we;
  logic [IW-1:0]       wr_addr;
  logic [BW-1:0]       wr_burst;
  logic                load_we;
  logic [IW-1:0]       load_slot;

  // Round robin walks from the slot after the last one run, wrapping at the table fill.
  always_comb begin
    rr_start = current_valid_r ? (CW+1)'(current_slot_r) + 1'b1 : '0;
    rr_sum   = rr_start + (CW+1)'(k_r);
    if (rr_sum >= (CW+1)'(entry_count_r)) begin
      rr_sum = rr_sum - (CW+1)'(entry_count_r);
    end
    scan_addr = (mode_r == pts_pkg::MODE_RR) ? rr_sum[IW-1:0] : k_r;
    rd_addr   = cmd.sel_best ? best_slot_r : scan_addr;
  end

  assign table_full  = (entry_count_r >= CW'(pts_pkg::TABLE_DEPTH));
  assign run_tick    = (item_r.command == pts_pkg::CMD_TICK) && !status.tick_empty;
  assign quantum_ext = BW'(quantum_r);
  assign burst_new   = (burst_q_r > quantum_ext) ? burst_q_r - quantum_ext : '0;
  assign fin         = (burst_new == '0);
  assign load_slot   = entry_count_r[IW-1:0];
  assign load_we     = cmd.commit && (item_r.command == pts_pkg::CMD_LOAD) && !table_full;

  always_comb begin
    status.is_load    = (item_r.command == pts_pkg::CMD_LOAD);
    status.tick_empty = (remaining_r == '0) || (entry_count_r == '0);
    status.keep_avail = (mode_r != pts_pkg::MODE_RR) && current_valid_r
                        && !done_r[current_slot_r];
    status.scan_last  = (CW'(k_r) == entry_count_r - 1'b1);
    status.out_free   = !out_valid_r || !out_stall;
  end

  // Candidate compare, one table entry per cycle behind the memory read.
  always_comb begin
    take = 1'b0;
    if (pend_valid_r && !done_r[pend_slot_r]) begin
      if (!best_found_r) begin
        take = 1'b1;
      end else begin
        case (mode_r)
          pts_pkg::MODE_SJF:  take = (burst_q_r < best_burst_r);
          pts_pkg::MODE_PRIO: take = (prio_q_r < best_prio_r);
          default:            take = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    k_nxt          = k_r;
    best_found_nxt = best_found_r;
    best_slot_nxt  = best_slot_r;
    best_burst_nxt = best_burst_r;
    best_prio_nxt  = best_prio_r;
    if (cmd.scan_init) begin
      k_nxt          = '0;
      best_found_nxt = 1'b0;
    end else if (cmd.keep_cur) begin
      best_slot_nxt = current_slot_r;
    end else begin
      if (cmd.scan_step) begin
        k_nxt = k_r + 1'b1;
      end
      if (take) begin
        best_found_nxt = 1'b1;
        best_slot_nxt  = pend_slot_r;
        best_burst_nxt = burst_q_r;
        best_prio_nxt  = prio_q_r;
      end
    end
  end

  always_comb begin
    done_nxt          = done_r;
    entry_count_nxt   = entry_count_r;
    remaining_nxt     = remaining_r;
    current_slot_nxt  = current_slot_r;
    current_valid_nxt = current_valid_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r && out_stall;
    mem_we            = 1'b0;
    wr_addr           = best_slot_r;
    wr_burst          = burst_new;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (item_r.command == pts_pkg::CMD_LOAD) begin
        if (table_full) begin
          out_nxt.all_done   = (remaining_r == '0);
          out_nxt.error_flag = 1'b1;
        end else begin
          done_nxt[load_slot] = 1'b0;
          entry_count_nxt     = entry_count_r + 1'b1;
          remaining_nxt       = remaining_r + 1'b1;
          out_nxt.ran_slot    = 4'(load_slot);
          mem_we              = 1'b1;
          wr_addr             = load_slot;
          wr_burst            = BW'(item_r.burst_time);
        end
      end else if (!run_tick) begin
        out_nxt.all_done   = 1'b1;
        out_nxt.error_flag = 1'b1;
      end else begin
        mem_we            = 1'b1;
        current_slot_nxt  = best_slot_r;
        current_valid_nxt = 1'b1;
        if (fin) begin
          done_nxt[best_slot_r] = 1'b1;
          remaining_nxt         = remaining_r - 1'b1;
        end
        out_nxt.ran_id     = id_q_r;
        out_nxt.ran_slot   = 4'(best_slot_r);
        out_nxt.burst_left = 16'(burst_new);
        out_nxt.finished   = fin;
        out_nxt.all_done   = (remaining_nxt == '0);
      end
    end
  end

  // Table memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      burst_mem[wr_addr] <= wr_burst;
    end
    if (load_we) begin
      prio_mem[load_slot] <= item_r.prio_value;
      id_mem[load_slot]   <= item_r.proc_id;
    end
    burst_q_r <= burst_mem[rd_addr];
    prio_q_r  <= prio_mem[rd_addr];
    id_q_r    <= id_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    k_r          <= k_nxt;
    pend_slot_r  <= scan_addr;
    best_slot_r  <= best_slot_nxt;
    best_burst_r <= best_burst_nxt;
    best_prio_r  <= best_prio_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r          <= '0;
      entry_count_r   <= '0;
      remaining_r     <= '0;
      current_slot_r  <= '0;
      current_valid_r <= 1'b0;
      mode_r          <= pts_pkg::MODE_FCFS;
      quantum_r       <= pts_pkg::QUANTUM_RESET;
      pend_valid_r    <= 1'b0;
      best_found_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      done_r          <= done_nxt;
      entry_count_r   <= entry_count_nxt;
      remaining_r     <= remaining_nxt;
      current_slot_r  <= current_slot_nxt;
      current_valid_r <= current_valid_nxt;
      pend_valid_r    <= cmd.scan_step;
      best_found_r    <= best_found_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_we && (cfg_index == pts_pkg::REG_SCHED_MODE)) begin
        mode_r <= cfg_wdata[1:0];
      end
      if (cfg_we && (cfg_index == pts_pkg::REG_QUANTUM)) begin
        quantum_r <= cfg_wdata[7:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_remaining_le_entries: assert property (@(posedge clk) disable iff (!rst_n)
    remaining_r <= entry_count_r)
    else $error("remaining count exceeds entry count");

  a_entries_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CW'(pts_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_run_unfinished: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && run_tick |-> !done_r[best_slot_r]
                               && (CW'(best_slot_r) < entry_count_r))
    else $error("tick runs a finished or unloaded slot");

  a_commit_presents: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");
`endif

endmodule

>>> design/process_table_scheduler.sv
`timescale 1ns / 1ps
// Top level of the process table scheduler: controller plus datapath.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
// The block holds a table of up to 16 processes, each loaded by a load transaction with an
// id, a burst time and a signed priority, and runs one quantum of one process per tick
// transaction. Every input transaction yields exactly one result transaction. The policy
// comes from the sched_mode register (first come first served, round robin, shortest job
// first, priority) and the units removed per tick from the quantum register; both must be
// written by the user through the cfg_ port only while the block is idle; the block itself
// does not enforce this. Items are processed one at a time: a tick that must choose a new
// process walks the table one entry per cycle through the single read port of the table
// memory, while a load, a tick that keeps running the current process and a tick that
// finds nothing to run skip that walk. The result sits in an output register, so a new
// transaction is accepted while the previous result still waits to be taken; the block
// only holds off in its last state until that register frees up. No clearing pass is
// needed after reset.
module process_table_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pts_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pts_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Commands and status between the sequencer and the datapath.
  pts_pkg::ctrl_cmd_t  cmd;
  pts_pkg::dp_status_t status;

  // The controller owns the input handshake and the order of scan, fetch and commit.
  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the table, the configuration registers and the result register.
  pts_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> test/process_table_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for process_table_scheduler: directed and random load/tick traffic
// with random idling on both channels, checked against a cycle-free scheduler predictor.
// Depends on pts_pkg and process_table_scheduler.
module process_table_scheduler_tb;

  localparam int CDW = pts_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  pts_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pts_pkg::out_item_t out_data;
  logic                           cfg_we = 1'b0;
  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  process_table_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock period.
  always #1 clk = ~clk;

  // Predictor copy of the process table. Entries above loaded_n are never read, so their
  // initial contents do not matter.
  logic [15:0]       burst_tab [pts_pkg::TABLE_DEPTH];
  logic signed [7:0] prio_tab  [pts_pkg::TABLE_DEPTH];
  logic [15:0]       id_tab    [pts_pkg::TABLE_DEPTH];
  bit                done_tab  [pts_pkg::TABLE_DEPTH];
  int                loaded_n = 0;
  int                open_n = 0;
  int                run_slot = 0;
  bit                run_held = 1'b0;
  logic [1:0]        mode_reg = pts_pkg::MODE_FCFS;
  logic [7:0]        quantum_reg = pts_pkg::QUANTUM_RESET;

  // Transactions waiting to be driven, and results owed by the block in acceptance order.
  pts_pkg::in_item_t  item_backlog [$];
  pts_pkg::out_item_t due_results [$];

  // Bookkeeping used to find quiet points between phases.
  int queued_total = 0;
  int checked_total = 0;
  int loads_issued = 0;
  int mismatch_count = 0;

  // Idle burst counters for the two sides, and a switch that turns idling off.
  int send_gap = 0;
  int hold_gap = 0;
  bit idle_on = 1'b1;

  // Chooses the slot that runs on the next tick. Round robin always walks on from the last
  // slot that ran. The other policies are non-preemptive: they keep the last slot while it is
  // unfinished, even across a policy change, and otherwise scan the table with ties going to
  // the lowest slot.
  function automatic int choose_slot();
    int best;
    bit found;
    int start;
    best = 0;
    found = 1'b0;
    if (mode_reg == pts_pkg::MODE_RR) begin
      start = run_held ? run_slot + 1 : 0;
      for (int i = 0; i < loaded_n; i++) begin
        if (!done_tab[(start + i) % loaded_n]) return (start + i) % loaded_n;
      end
      return 0;
    end
    if (run_held && run_slot < loaded_n && !done_tab[run_slot]) return run_slot;
    for (int i = 0; i < loaded_n; i++) begin
      if (done_tab[i]) continue;
      if (!found) begin
        best = i;
        found = 1'b1;
        if (mode_reg == pts_pkg::MODE_FCFS) break;
      end else if (mode_reg == pts_pkg::MODE_SJF && burst_tab[i] < burst_tab[best]) begin
        best = i;
      end else if (mode_reg == pts_pkg::MODE_PRIO && prio_tab[i] < prio_tab[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Applies one accepted transaction to the predictor and returns the result it owes.
  function automatic pts_pkg::out_item_t sched_predict(pts_pkg::in_item_t it);
    pts_pkg::out_item_t r;
    int s;
    logic [15:0] b;
    r = '0;
    if (it.command == pts_pkg::CMD_LOAD) begin
      if (loaded_n >= pts_pkg::TABLE_DEPTH) begin
        // The table never empties, so every load past the sixteenth is refused.
        r.all_done = (open_n == 0);
        r.error_flag = 1'b1;
      end else begin
        id_tab[loaded_n] = it.proc_id;
        burst_tab[loaded_n] = it.burst_time;
        prio_tab[loaded_n] = it.prio_value;
        done_tab[loaded_n] = 1'b0;
        r.ran_slot = loaded_n[3:0];
        loaded_n++;
        open_n++;
      end
    end else if (open_n == 0 || loaded_n == 0) begin
      // Nothing left to run: flagged, and the table is left alone.
      r.all_done = 1'b1;
      r.error_flag = 1'b1;
    end else begin
      s = choose_slot();
      b = burst_tab[s];
      // The burst saturates at zero; a zero burst finishes on its first tick.
      b = (b > 16'(quantum_reg)) ? b - 16'(quantum_reg) : '0;
      burst_tab[s] = b;
      if (b == '0) begin
        done_tab[s] = 1'b1;
        open_n--;
      end
      run_slot = s;
      run_held = 1'b1;
      r.ran_id = id_tab[s];
      r.ran_slot = s[3:0];
      r.burst_left = b;
      r.finished = (b == '0);
      r.all_done = (open_n == 0);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_load(input logic [15:0] id, input logic [15:0] burst,
                            input logic signed [7:0] prio);
    pts_pkg::in_item_t it;
    it.command = pts_pkg::CMD_LOAD;
    it.proc_id = id;
    it.burst_time = burst;
    it.prio_value = prio;
    item_backlog.push_back(it);
    queued_total++;
    loads_issued++;
  endtask

  // The load fields of a tick are don't-care to the block, so they carry random bits.
  task automatic queue_tick();
    pts_pkg::in_item_t it;
    it.command = pts_pkg::CMD_TICK;
    it.proc_id = 16'($urandom);
    it.burst_time = 16'($urandom);
    it.prio_value = 8'($urandom);
    item_backlog.push_back(it);
    queued_total++;
  endtask

  // Waits until every queued transaction has produced its result, then lets the block run
  // out its longest tick latency before anything else happens.
  task automatic settle();
    do @(posedge clk); while (checked_total != queued_total);
    repeat (30) @(posedge clk);
  endtask

  // Called right after a rising edge. Ends with the enable low across a rising edge so that
  // back-to-back writes never assign the enable twice in one time step.
  task automatic write_reg(input logic [pts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pts_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    if (idx == pts_pkg::REG_SCHED_MODE) mode_reg = val[1:0];
    else if (idx == pts_pkg::REG_QUANTUM) quantum_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic. While free slots remain, about one transaction in six is a load; after
  // that loads are rare and only exercise the full-table refusal. Most loaded bursts are
  // short so that entries finish and the policies get to pick new ones, with a few long ones
  // that stay around.
  task automatic queue_random(input int n);
    logic [15:0] burst;
    for (int k = 0; k < n; k++) begin
      if (loads_issued < pts_pkg::TABLE_DEPTH ? $urandom_range(0, 5) == 0
                                              : $urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 9)) inside
          [0:5]:   burst = 16'($urandom_range(0, 15));
          [6:8]:   burst = 16'($urandom_range(16, 300));
          default: burst = 16'($urandom);
        endcase
        queue_load(16'($urandom), burst, 8'($urandom));
      end else begin
        queue_tick();
      end
    end
  endtask

  // Input driver. A transaction leaves the bus only once accepted, and the expected result
  // is computed at the edge of acceptance. After a transaction is placed on the bus, an idle
  // burst may follow it.
  always @(posedge clk) begin : drive_proc
    bit took;
    took = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(sched_predict(in_data));
        took = 1'b1;
      end
      if (!in_valid || took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          in_data <= item_backlog.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each accepted result is checked field by field against the oldest
  // expectation. The stall line is raised in random bursts independent of out_valid.
  always @(posedge clk) begin : watch_proc
    pts_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_total++;
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = due_results.pop_front();
          if (out_data.ran_id !== want.ran_id)
            flag_mismatch("ran_id", int'(out_data.ran_id), int'(want.ran_id));
          if (out_data.ran_slot !== want.ran_slot)
            flag_mismatch("ran_slot", int'(out_data.ran_slot), int'(want.ran_slot));
          if (out_data.burst_left !== want.burst_left)
            flag_mismatch("burst_left", int'(out_data.burst_left), int'(want.burst_left));
          if (out_data.finished !== want.finished)
            flag_mismatch("finished", int'(out_data.finished), int'(want.finished));
          if (out_data.all_done !== want.all_done)
            flag_mismatch("all_done", int'(out_data.all_done), int'(want.all_done));
          if (out_data.error_flag !== want.error_flag)
            flag_mismatch("error_flag", int'(out_data.error_flag), int'(want.error_flag));
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus sequence. Configuration is only written at quiet points, after settle().
  initial begin : stimulus
    logic [1:0] mode_cycle [4];
    int q;
    mode_cycle = '{pts_pkg::MODE_RR, pts_pkg::MODE_SJF, pts_pkg::MODE_PRIO,
                   pts_pkg::MODE_FCFS};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset policy (first come first served, quantum 2). A tick on an empty table is
    // refused. The loads hit the id, burst and priority extremes; the first entry has a zero
    // burst and finishes on its first tick.
    queue_tick();
    queue_load(16'hFFFF, 16'd0, -8'sd128);
    queue_load(16'h0000, 16'hFFFF, 8'sd127);
    queue_load(16'h1234, 16'd5, 8'sd0);
    queue_load(16'hA5A5, 16'd3, -8'sd1);
    queue_tick();
    settle();

    // Shortest job first with the largest quantum. The running entry is finished, so the
    // scan picks the short jobs in order of burst and leaves the long one for later.
    write_reg(pts_pkg::REG_SCHED_MODE, CDW'(pts_pkg::MODE_SJF));
    write_reg(pts_pkg::REG_QUANTUM, 8'd255);
    queue_load(16'h0007, 16'd9, -8'sd128);
    repeat (3) queue_tick();
    settle();

    // Priority with a zero quantum: two entries tie on priority and the lower slot wins;
    // its burst is not lowered, so it keeps running.
    write_reg(pts_pkg::REG_SCHED_MODE, CDW'(pts_pkg::MODE_PRIO));
    write_reg(pts_pkg::REG_QUANTUM, 8'd0);
    queue_load(16'h0008, 16'd0, 8'sd5);
    queue_load(16'h0009, 16'd200, -8'sd5);
    queue_load(16'h000A, 16'd0, -8'sd5);
    repeat (2) queue_tick();
    settle();

    // Round robin picks up after the slot that ran last under the priority policy.
    write_reg(pts_pkg::REG_SCHED_MODE, CDW'(pts_pkg::MODE_RR));
    write_reg(pts_pkg::REG_QUANTUM, 8'd2);
    repeat (3) queue_tick();

    // Random phases cycle through every policy; the quantum is 1 in the first, 255 in the second
    // and random from 1 to 255 later. Some phases run without idling, and so does the last.
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      write_reg(pts_pkg::REG_SCHED_MODE, CDW'(mode_cycle[ph % 4]));
      case (ph)
        0:       q = 1;
        1:       q = 255;
        default: q = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 255);
      endcase
      write_reg(pts_pkg::REG_QUANTUM, q[7:0]);
      idle_on = (ph == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      queue_random(55);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("process_table_scheduler verification clean");
    end else begin
      $display("process_table_scheduler verification failed");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run.
  initial begin : watchdog
    #1000000;
    $display("process_table_scheduler verification failed");
    $finish;
  end

endmodule

>>> process_table_scheduler.f
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_datapath.sv
design/process_table_scheduler.sv
test/process_table_scheduler_tb.sv
